>>> rtl/rle_ctd_pkg.sv
// Package for the RLE column tile decoder: command, phase and register types and constants.
// No dependencies; imported by every module of the decoder.
package rle_ctd_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned ROW_W  = 9;
   localparam int unsigned CSR_INDEX_W = 2;

   localparam logic [BYTE_W-1:0] COUNT_MASK      = 8'h7f;
   localparam int unsigned       REPEAT_FLAG_BIT = 7;
   localparam logic [BYTE_W-1:0] ROW_LIMIT_RESET = 8'd157;
   localparam logic [ROW_W-1:0]  ROW_STEP        = 9'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_COLUMN = 2'd0,
      CSR_START_ROW    = 2'd1,
      CSR_ROW_LIMIT    = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      PH_COUNT = 5'b00001,
      PH_REP_A = 5'b00010,
      PH_REP_B = 5'b00100,
      PH_LIT_A = 5'b01000,
      PH_LIT_B = 5'b10000
   } phase_type;

   // One queue entry: a position reload, or a pattern pair drawn count times.
   typedef struct packed {
      logic              reload;
      logic              draw;
      logic [BYTE_W-1:0] load_column;
      logic [BYTE_W-1:0] load_row;
      logic [BYTE_W-1:0] top;
      logic [BYTE_W-1:0] bottom;
      logic [BYTE_W-1:0] count;
   } cmd_type;

endpackage

>>> rtl/rle_ctd_req_if.sv
// Request channel of the RLE column tile decoder: one compressed body byte per request.
// Standalone; no package needed.
interface rle_ctd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       image_start;

   modport source (output valid, data_byte, image_start, input ready);
   modport sink   (input valid, data_byte, image_start, output ready);
endinterface

>>> rtl/rle_ctd_rsp_if.sv
// Result channel of the RLE column tile decoder: one or two tile draws per item.
// Standalone; no package needed.
interface rle_ctd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] column;
   logic [8:0] row;
   logic [7:0] top_pattern;
   logic [7:0] bottom_pattern;
   logic       second_valid;
   logic [7:0] column_second;
   logic [8:0] row_second;
   logic       last_of_run;

   modport source (output valid, column, row, top_pattern, bottom_pattern, second_valid,
                   column_second, row_second, last_of_run, input ready);
   modport sink   (input valid, column, row, top_pattern, bottom_pattern, second_valid,
                   column_second, row_second, last_of_run, output ready);
endinterface

>>> rtl/rle_ctd_front.sv
// Byte parser: tracks count and pattern bytes and emits reload and draw commands.
// Depends on rle_ctd_pkg and rle_ctd_req_if.
module rle_ctd_front
   import rle_ctd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   rle_ctd_req_if.sink       req_ch,
   input  logic [BYTE_W-1:0] start_column,
   input  logic [BYTE_W-1:0] start_row,
   input  logic              push_ready,
   output logic              push_valid,
   output cmd_type           push_cmd
);

   phase_type         phase_ff, phase_in, phase_cur;
   logic [BYTE_W-1:0] run_ff, run_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic              accept;
   logic              draw;
   logic [BYTE_W-1:0] draw_count;
   logic [BYTE_W-1:0] b;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;
   assign b            = req_ch.data_byte;
   assign phase_cur    = req_ch.image_start ? PH_COUNT : phase_ff;

   always_comb begin
      phase_in   = phase_ff;
      run_in     = run_ff;
      held_in    = held_ff;
      draw       = 1'b0;
      draw_count = run_ff;
      unique case (phase_cur)
         PH_COUNT: begin
            run_in   = (b & COUNT_MASK) + 8'd1;
            phase_in = b[REPEAT_FLAG_BIT] ? PH_REP_A : PH_LIT_A;
         end
         PH_REP_A: begin
            held_in  = b;
            phase_in = PH_REP_B;
         end
         PH_LIT_A: begin
            held_in  = b;
            phase_in = PH_LIT_B;
         end
         PH_REP_B: begin
            draw       = 1'b1;
            draw_count = run_ff;
            run_in     = '0;
            phase_in   = PH_COUNT;
         end
         PH_LIT_B: begin
            draw       = 1'b1;
            draw_count = 8'd1;
            run_in     = run_ff - 8'd1;
            phase_in   = (run_ff == 8'd1) ? PH_COUNT : PH_LIT_A;
         end
         default: begin
            phase_in = PH_COUNT;
         end
      endcase
   end

   assign push_valid           = accept && (req_ch.image_start || draw);
   assign push_cmd.reload      = req_ch.image_start;
   assign push_cmd.draw        = draw;
   assign push_cmd.load_column = start_column;
   assign push_cmd.load_row    = start_row;
   assign push_cmd.top         = held_ff;
   assign push_cmd.bottom      = b;
   assign push_cmd.count       = draw_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_COUNT;
         run_ff   <= '0;
         held_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         held_ff  <= held_in;
      end
   end

endmodule

>>> rtl/rle_ctd_queue.sv
// Small command queue between the parser and the drawing engine.
// Depends on rle_ctd_pkg.
module rle_ctd_queue
   import rle_ctd_pkg::*;
#(
   parameter int unsigned DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   output logic    head_valid,
   output cmd_type head_cmd,
   input  logic    pop
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   cmd_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("request pushed into full queue");

endmodule

>>> rtl/rle_ctd_back.sv
// Drawing engine: holds the tile position; one or two draws a cycle while output is free.
// Depends on rle_ctd_pkg and rle_ctd_rsp_if.
module rle_ctd_back
   import rle_ctd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] start_row,
   input  logic [BYTE_W-1:0] row_limit,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   output logic              pop,
   rle_ctd_rsp_if.source     rsp_ch
);

   logic [BYTE_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              active_ff, active_in;
   logic [BYTE_W-1:0] left_ff, left_in;
   logic [BYTE_W-1:0] top_ff, top_in;
   logic [BYTE_W-1:0] bottom_ff, bottom_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_column_ff, rsp_column_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [BYTE_W-1:0] rsp_top_ff, rsp_top_in;
   logic [BYTE_W-1:0] rsp_bottom_ff, rsp_bottom_in;
   logic              rsp_second_ff, rsp_second_in;
   logic [BYTE_W-1:0] rsp_column2_ff, rsp_column2_in;
   logic [ROW_W-1:0]  rsp_row2_ff, rsp_row2_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              slot_free, produce, two;
   logic [ROW_W-1:0]  r1, r2, row1, row2, reload_row, limit;
   logic [BYTE_W-1:0] col1, col2, left_next;
   logic              wrap1, wrap2;

   assign reload_row = {1'b0, start_row};
   assign limit      = {1'b0, row_limit};

   // Position after the first and the second draw
   assign r1    = row_ff + ROW_STEP;
   assign wrap1 = r1 > limit;
   assign col1  = wrap1 ? col_ff + 8'd1 : col_ff;
   assign row1  = wrap1 ? reload_row : r1;
   assign r2    = row1 + ROW_STEP;
   assign wrap2 = r2 > limit;
   assign col2  = wrap2 ? col1 + 8'd1 : col1;
   assign row2  = wrap2 ? reload_row : r2;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign produce   = active_ff && slot_free;
   assign pop       = head_valid && !active_ff;
   assign two       = (left_ff > 8'd1);
   assign left_next = left_ff - (two ? 8'd2 : 8'd1);

   always_comb begin
      col_in         = col_ff;
      row_in         = row_ff;
      active_in      = active_ff;
      left_in        = left_ff;
      top_in         = top_ff;
      bottom_in      = bottom_ff;
      rsp_valid_in   = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      rsp_column_in  = rsp_column_ff;
      rsp_row_in     = rsp_row_ff;
      rsp_top_in     = rsp_top_ff;
      rsp_bottom_in  = rsp_bottom_ff;
      rsp_second_in  = rsp_second_ff;
      rsp_column2_in = rsp_column2_ff;
      rsp_row2_in    = rsp_row2_ff;
      rsp_last_in    = rsp_last_ff;
      if (pop) begin
         if (head_cmd.reload) begin
            col_in = head_cmd.load_column;
            row_in = {1'b0, head_cmd.load_row};
         end
         if (head_cmd.draw) begin
            active_in = 1'b1;
            left_in   = head_cmd.count;
            top_in    = head_cmd.top;
            bottom_in = head_cmd.bottom;
         end
      end else if (produce) begin
         rsp_valid_in   = 1'b1;
         rsp_column_in  = col_ff;
         rsp_row_in     = row_ff;
         rsp_top_in     = top_ff;
         rsp_bottom_in  = bottom_ff;
         rsp_second_in  = two;
         rsp_column2_in = two ? col1 : '0;
         rsp_row2_in    = two ? row1 : '0;
         rsp_last_in    = (left_next == '0);
         col_in         = two ? col2 : col1;
         row_in         = two ? row2 : row1;
         left_in        = left_next;
         active_in      = (left_next != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         active_ff    <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         active_ff    <= active_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff         <= top_in;
      bottom_ff      <= bottom_in;
      rsp_column_ff  <= rsp_column_in;
      rsp_row_ff     <= rsp_row_in;
      rsp_top_ff     <= rsp_top_in;
      rsp_bottom_ff  <= rsp_bottom_in;
      rsp_second_ff  <= rsp_second_in;
      rsp_column2_ff <= rsp_column2_in;
      rsp_row2_ff    <= rsp_row2_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.column         = rsp_column_ff;
   assign rsp_ch.row            = rsp_row_ff;
   assign rsp_ch.top_pattern    = rsp_top_ff;
   assign rsp_ch.bottom_pattern = rsp_bottom_ff;
   assign rsp_ch.second_valid   = rsp_second_ff;
   assign rsp_ch.column_second  = rsp_column2_ff;
   assign rsp_ch.row_second     = rsp_row2_ff;
   assign rsp_ch.last_of_run    = rsp_last_ff;

   a_active_left: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (left_ff != '0))
      else $error("draw run active with nothing left");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (produce && left_next == '0) |=> !active_ff)
      else $error("run still active after last request");

   a_single_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_second_ff) |-> (rsp_column2_ff == '0 && rsp_row2_ff == '0))
      else $error("second draw position not cleared");

endmodule

>>> rtl/rle_column_tile_decoder.sv
// RLE column tile decoder: parser front, command queue, drawing engine.
// A result is registered: the command of its final pattern byte passes through the queue,
// the engine's run registers and the output register (engine idle). Throughput: one request
// byte a cycle while the queue has room; the engine loads each command, then issues
// one result (up to two draws) a cycle while the output slot is free.
// Reset (synchronous): parser, queue, position and output cleared; registers to defaults.
module rle_column_tile_decoder
   import rle_ctd_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
)
(
   input  logic                   clock,
   input  logic                   reset,
   rle_ctd_req_if.sink            req_ch,
   rle_ctd_rsp_if.source          rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [BYTE_W-1:0]      csr_wdata
);

   logic [BYTE_W-1:0] start_column_ff;
   logic [BYTE_W-1:0] start_row_ff;
   logic [BYTE_W-1:0] row_limit_ff;

   logic    push_valid, push_ready, head_valid, pop;
   cmd_type push_cmd, head_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_column_ff <= '0;
         start_row_ff    <= '0;
         row_limit_ff    <= ROW_LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_COLUMN: start_column_ff <= csr_wdata;
            CSR_START_ROW:    start_row_ff    <= csr_wdata;
            CSR_ROW_LIMIT:    row_limit_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rle_ctd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .start_column (start_column_ff),
      .start_row    (start_row_ff),
      .push_ready   (push_ready),
      .push_valid   (push_valid),
      .push_cmd     (push_cmd)
   );

   rle_ctd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   rle_ctd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .start_row  (start_row_ff),
      .row_limit  (row_limit_ff),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule
